[rtl/scba_pkg.sv]
// Shared types, constants and size-class functions of the size-class block allocator.
package scba_pkg;

	localparam int unsigned POOL_BYTES      = 1048576;
	localparam int unsigned MAX_CLASS_BYTES = 32768;
	localparam int unsigned CLASS_COUNT     = 40;
	localparam int unsigned GRANULE_BYTES   = 16;

	localparam int unsigned SMALL_STEP    = 16;
	localparam int unsigned SMALL_MAX     = 128;
	localparam int unsigned SMALL_CLASSES = 8;
	localparam int unsigned MIN_PAGE      = 4096;
	localparam int unsigned FIRST_LOG2    = 7;
	localparam int unsigned SUB_BASE      = 5;

	localparam int unsigned STEP_SHIFT = $clog2(SMALL_STEP);
	localparam int unsigned GRAN_SHIFT = $clog2(GRANULE_BYTES);

	localparam int unsigned ADDR_W  = 20;
	localparam int unsigned SIZE_W  = 24;
	localparam int unsigned CLS_W   = 6;
	localparam int unsigned BYTES_W = 16;
	localparam int unsigned USED_W  = 21;
	localparam int unsigned PAGE_W  = 21;

	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 2;

	localparam logic [APB_ADDR_W-1:0] ADDR_PAGE_BYTES = 2'd0;

	typedef enum logic [0:0] {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_ZERO      = 2'd1,
		STAT_EXHAUSTED = 2'd2,
		STAT_OVERSIZE  = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t               command;
		logic [SIZE_W-1:0]  request_size;
		logic [ADDR_W-1:0]  block_address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  result_address;
		status_t            status;
		logic [CLS_W-1:0]   class_index;
		logic [BYTES_W-1:0] block_bytes;
		logic [USED_W-1:0]  used_bytes;
	} rsp_t;

	// Map a byte size to its class; CLASS_COUNT marks oversize, zero maps to class 0.
	function automatic logic [CLS_W-1:0] size_class(input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] v;
		int unsigned p;
		int unsigned sub;
		int unsigned cls;
		v = size - SIZE_W'(1);
		p = FIRST_LOG2;
		for (int i = FIRST_LOG2 + 1; i < SIZE_W; i++) begin
			if (v[i]) p = i;
		end
		sub = int'(v[p-2 +: 2]);
		cls = SMALL_CLASSES + (p - FIRST_LOG2) * 4 + sub;
		if (size == '0) return '0;
		if (size <= SIZE_W'(SMALL_MAX)) return CLS_W'(v >> STEP_SHIFT);
		if (size > SIZE_W'(MAX_CLASS_BYTES)) return CLS_W'(CLASS_COUNT);
		if (cls >= CLASS_COUNT) return CLS_W'(CLASS_COUNT);
		return CLS_W'(cls);
	endfunction

	// Block bytes of a class.
	function automatic logic [BYTES_W-1:0] class_size(input logic [CLS_W-1:0] cls);
		logic [CLS_W-1:0] rel;
		int unsigned sh;
		rel = cls - CLS_W'(SMALL_CLASSES);
		sh = FIRST_LOG2 + int'(rel >> 2) - 2;
		if (cls < CLS_W'(SMALL_CLASSES)) return BYTES_W'((int'(cls) + 1) * SMALL_STEP);
		return BYTES_W'((SUB_BASE + int'(rel[1:0])) << sh);
	endfunction

endpackage

[rtl/scba_heads.sv]
// Free-list head memory: one entry per size class, valid bits, read bypass.
module scba_heads #(
	parameter int unsigned ENTRY_W = 17
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 rd_en,
	input  logic [$clog2(scba_pkg::CLASS_COUNT)-1:0] rd_addr,
	output logic [ENTRY_W-1:0]                   rd_entry,
	input  logic                                 wr_en,
	input  logic [$clog2(scba_pkg::CLASS_COUNT)-1:0] wr_addr,
	input  logic [ENTRY_W-1:0]                   wr_entry
);
	import scba_pkg::*;

	logic [ENTRY_W-1:0]     mem [CLASS_COUNT];
	logic [CLASS_COUNT-1:0] written_q;
	logic [ENTRY_W-1:0]     rd_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q  <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) written_q[wr_addr] <= 1'b1;
			if (rd_en) begin
				// forward a write that lands on the same class in this cycle
				if (wr_en && wr_addr == rd_addr) begin
					rd_valid_q <= 1'b1;
				end else begin
					rd_valid_q <= written_q[rd_addr];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr) begin
				rd_q <= wr_entry;
			end else begin
				rd_q <= mem[rd_addr];
			end
		end
	end

	// a class never written reads as an empty list
	assign rd_entry = rd_valid_q ? rd_q : '0;

endmodule

[rtl/scba_links.sv]
// Granule-indexed link memory holding the next pointers of the free lists.
module scba_links #(
	parameter int unsigned DEPTH   = 65536,
	parameter int unsigned ENTRY_W = 17
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [ENTRY_W-1:0]       rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [ENTRY_W-1:0]       wr_data
);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

[rtl/scba_ctrl.sv]
// Request sequencer: class decode, list pop and push, bump carving, usage and result register.
module scba_ctrl #(
	parameter int unsigned POOL_BYTES = scba_pkg::POOL_BYTES,
	parameter int unsigned GRAN_W     = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic [scba_pkg::PAGE_W-1:0]              page_bytes,
	input  logic                                     req_valid,
	output logic                                     req_stall,
	input  scba_pkg::req_t                           req,
	output logic                                     rsp_valid,
	input  logic                                     rsp_stall,
	output scba_pkg::rsp_t                           rsp,
	output logic                                     head_rd_en,
	output logic [$clog2(scba_pkg::CLASS_COUNT)-1:0] head_rd_addr,
	input  logic [GRAN_W:0]                          head_rd_entry,
	output logic                                     head_wr_en,
	output logic [$clog2(scba_pkg::CLASS_COUNT)-1:0] head_wr_addr,
	output logic [GRAN_W:0]                          head_wr_entry,
	output logic                                     link_rd_en,
	output logic [GRAN_W-1:0]                        link_rd_addr,
	input  logic [GRAN_W:0]                          link_rd_data,
	output logic                                     link_wr_en,
	output logic [GRAN_W-1:0]                        link_wr_addr,
	output logic [GRAN_W:0]                          link_wr_data
);
	import scba_pkg::*;

	localparam int unsigned CUR_W   = $clog2(POOL_BYTES + 1);
	localparam int unsigned PAY_W   = PAGE_W + 1;
	localparam int unsigned SUM_W   = (CUR_W > PAY_W ? CUR_W : PAY_W) + 1;
	localparam int unsigned HEAD_AW = $clog2(CLASS_COUNT);
	localparam logic [USED_W-1:0] USED_MAX = '1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HEAD,
		S_POP
	} state_t;

	state_t state_q;

	// effective page size: at least the minimum page, rounded up to a granule
	logic [PAGE_W-1:0] page_floor;
	logic [PAY_W-1:0]  page_eff;

	assign page_floor = (page_bytes < PAGE_W'(MIN_PAGE)) ? PAGE_W'(MIN_PAGE) : page_bytes;
	assign page_eff   = (PAY_W'(page_floor) + PAY_W'(GRANULE_BYTES - 1))
		& ~PAY_W'(GRANULE_BYTES - 1);

	// front decode of the incoming item
	logic               take;
	logic [CLS_W-1:0]   cls_f;
	logic [BYTES_W-1:0] blk_f;
	logic [PAY_W-1:0]   pay_f;
	logic               zero_f;
	logic               over_f;

	assign req_stall = !(state_q == S_IDLE || state_q == S_POP);
	assign take      = req_valid && !req_stall;
	assign cls_f     = size_class(req.request_size);
	assign blk_f     = class_size(cls_f);
	assign zero_f    = (req.request_size == '0);
	assign over_f    = !zero_f && (cls_f >= CLS_W'(CLASS_COUNT));
	assign pay_f     = (PAY_W'(blk_f) > page_eff) ? PAY_W'(blk_f) : page_eff;

	assign head_rd_en   = take && !zero_f && !over_f;
	assign head_rd_addr = HEAD_AW'(cls_f);

	cmd_t               cmd_s1;
	logic               zero_s1;
	logic               over_s1;
	logic [CLS_W-1:0]   cls_s1;
	logic [BYTES_W-1:0] blk_s1;
	logic [PAY_W-1:0]   pay_s1;
	logic [GRAN_W-1:0]  gidx_s1;

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1  <= req.command;
			zero_s1 <= zero_f;
			over_s1 <= over_f;
			cls_s1  <= cls_f;
			blk_s1  <= blk_f;
			pay_s1  <= pay_f;
			gidx_s1 <= GRAN_W'(req.block_address >> GRAN_SHIFT);
		end
	end

	// list head and bump decision
	logic [CUR_W-1:0]  cursor_q;
	logic [CUR_W-1:0]  page_limit_q;
	logic [CUR_W-1:0]  pool_top_q;
	logic [USED_W-1:0] used_q;
	logic [USED_W-1:0] peak_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              head_valid;
	logic [GRAN_W-1:0] head_idx;
	logic              act;
	logic              alloc;
	logic              dealloc;
	logic              pop;
	logic              bump;
	logic              need_page;
	logic              fits;
	logic              bump_ok;
	logic              fail;
	logic [SUM_W-1:0]  page_end;
	logic [CUR_W-1:0]  base;
	logic [USED_W:0]   used_sum;
	logic [USED_W-1:0] used_next;
	logic              rsp_free;
	logic              commit;
	rsp_t              rsp_d;

	assign head_valid = head_rd_entry[GRAN_W];
	assign head_idx   = head_rd_entry[GRAN_W-1:0];
	assign act        = !zero_s1 && !over_s1;
	assign alloc      = act && (cmd_s1 == CMD_ALLOC);
	assign dealloc    = act && (cmd_s1 == CMD_FREE);
	assign pop        = alloc && head_valid;
	assign bump       = alloc && !head_valid;
	assign need_page  = SUM_W'(page_limit_q - cursor_q) < SUM_W'(blk_s1);
	assign page_end   = SUM_W'(pool_top_q) + SUM_W'(pay_s1);
	assign fits       = page_end <= SUM_W'(POOL_BYTES);
	assign bump_ok    = bump && (!need_page || fits);
	assign fail       = bump && !bump_ok;
	assign base       = need_page ? pool_top_q : cursor_q;
	assign used_sum   = (USED_W + 1)'(used_q) + (USED_W + 1)'(blk_s1);

	always_comb begin
		used_next = used_q;
		if (pop || bump_ok) begin
			used_next = (used_sum > (USED_W + 1)'(USED_MAX)) ? USED_MAX : used_sum[USED_W-1:0];
		end else if (dealloc) begin
			used_next = (used_q > USED_W'(blk_s1)) ? used_q - USED_W'(blk_s1) : '0;
		end
	end

	always_comb begin
		rsp_d = '0;
		if (pop) begin
			rsp_d.result_address = ADDR_W'({head_idx, {GRAN_SHIFT{1'b0}}});
		end else if (bump_ok) begin
			rsp_d.result_address = ADDR_W'(base);
		end
		if (zero_s1) begin
			rsp_d.status = STAT_ZERO;
		end else if (over_s1) begin
			rsp_d.status = STAT_OVERSIZE;
		end else if (fail) begin
			rsp_d.status = STAT_EXHAUSTED;
		end else begin
			rsp_d.status = STAT_OK;
		end
		rsp_d.class_index = cls_s1;
		rsp_d.block_bytes = (pop || bump_ok || dealloc) ? blk_s1 : '0;
		rsp_d.used_bytes  = used_next;
	end

	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign commit   = (state_q == S_HEAD) && rsp_free;

	// memory traffic: push on free, link read on pop, head write-back in the following cycle
	assign link_wr_en    = commit && dealloc;
	assign link_wr_addr  = gidx_s1;
	assign link_wr_data  = head_rd_entry;
	assign link_rd_en    = commit && pop;
	assign link_rd_addr  = head_idx;
	assign head_wr_en    = (commit && dealloc) || (state_q == S_POP);
	assign head_wr_addr  = HEAD_AW'(cls_s1);
	assign head_wr_entry = (state_q == S_POP) ? link_rd_data : {1'b1, gidx_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) state_q <= S_HEAD;
				end
				S_HEAD: begin
					if (rsp_free) state_q <= pop ? S_POP : S_IDLE;
				end
				S_POP: begin
					state_q <= take ? S_HEAD : S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (commit) begin
				rsp_q       <= rsp_d;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q     <= '0;
			page_limit_q <= '0;
			pool_top_q   <= '0;
			used_q       <= '0;
			peak_q       <= '0;
		end else if (commit) begin
			if (bump_ok) begin
				if (need_page) begin
					// open a new page at the pool top, drop the old tail
					page_limit_q <= CUR_W'(page_end);
					pool_top_q   <= CUR_W'(page_end);
					cursor_q     <= pool_top_q + CUR_W'(blk_s1);
				end else begin
					cursor_q <= cursor_q + CUR_W'(blk_s1);
				end
			end
			used_q <= used_next;
			if (used_next > peak_q) peak_q <= used_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/size_class_block_allocator_unit.sv]
// Top level of the size-class block allocator: register port, memories and sequencer.
//
// Allocates and frees blocks of a fixed pool by size class. Requests enter on
// req (valid/stall) as an allocate or free command with a byte size and, for a
// free, the block address. Each request gives exactly one item on rsp: the
// block address, a status, the size class, the class block bytes and the bytes
// in use after the request.
// A request is taken into the decode registers and the head memory read,
// then its result into the output register. No new request is taken while
// one is in the head stage. A list pop reads the link memory at the result
// edge and writes the new head back in the cycle after, which overlaps with
// the next request (a same-class read is forwarded).
// A stalled result is held in the output register; the request behind it
// waits in the decode stage and req_stall stays high until the result is taken.
// Reset empties every class list through per-class valid bits (no clearing
// pass), zeroes the cursors and usage and sets page_bytes to 4096. The link
// memory is not cleared; pready is always high. The user must write page_bytes
// (APB, byte address 0) only while the block is idle; the block does not check it.
module size_class_block_allocator_unit #(
	parameter int unsigned POOL_BYTES = scba_pkg::POOL_BYTES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [scba_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [scba_pkg::APB_DATA_W-1:0] pwdata,
	output logic [scba_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  scba_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output scba_pkg::rsp_t                  rsp
);
	import scba_pkg::*;

	localparam int unsigned LINK_DEPTH = POOL_BYTES / GRANULE_BYTES;
	localparam int unsigned GRAN_W     = $clog2(LINK_DEPTH);
	localparam int unsigned ENTRY_W    = GRAN_W + 1;
	localparam int unsigned HEAD_AW    = $clog2(CLASS_COUNT);

	// register port
	logic [PAGE_W-1:0] page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= PAGE_W'(MIN_PAGE);
		end else if (psel && penable && pwrite && paddr == ADDR_PAGE_BYTES) begin
			page_q <= pwdata[PAGE_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_PAGE_BYTES) ? APB_DATA_W'(page_q) : '0;

	logic               head_rd_en;
	logic [HEAD_AW-1:0] head_rd_addr;
	logic [ENTRY_W-1:0] head_rd_entry;
	logic               head_wr_en;
	logic [HEAD_AW-1:0] head_wr_addr;
	logic [ENTRY_W-1:0] head_wr_entry;
	logic               link_rd_en;
	logic [GRAN_W-1:0]  link_rd_addr;
	logic [ENTRY_W-1:0] link_rd_data;
	logic               link_wr_en;
	logic [GRAN_W-1:0]  link_wr_addr;
	logic [ENTRY_W-1:0] link_wr_data;

	scba_heads #(
		.ENTRY_W (ENTRY_W)
	) u_heads (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (head_rd_en),
		.rd_addr  (head_rd_addr),
		.rd_entry (head_rd_entry),
		.wr_en    (head_wr_en),
		.wr_addr  (head_wr_addr),
		.wr_entry (head_wr_entry)
	);

	scba_links #(
		.DEPTH   (LINK_DEPTH),
		.ENTRY_W (ENTRY_W)
	) u_links (
		.clk     (clk),
		.rd_en   (link_rd_en),
		.rd_addr (link_rd_addr),
		.rd_data (link_rd_data),
		.wr_en   (link_wr_en),
		.wr_addr (link_wr_addr),
		.wr_data (link_wr_data)
	);

	scba_ctrl #(
		.POOL_BYTES (POOL_BYTES),
		.GRAN_W     (GRAN_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.page_bytes    (page_q),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.head_rd_en    (head_rd_en),
		.head_rd_addr  (head_rd_addr),
		.head_rd_entry (head_rd_entry),
		.head_wr_en    (head_wr_en),
		.head_wr_addr  (head_wr_addr),
		.head_wr_entry (head_wr_entry),
		.link_rd_en    (link_rd_en),
		.link_rd_addr  (link_rd_addr),
		.link_rd_data  (link_rd_data),
		.link_wr_en    (link_wr_en),
		.link_wr_addr  (link_wr_addr),
		.link_wr_data  (link_wr_data)
	);

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while the previous one is still decoding");

	a_pop_writeback: assert property (@(posedge clk) disable iff (!arst_n)
		link_rd_en |=> head_wr_en)
		else $error("list pop did not write back the new head");

	a_push_pair: assert property (@(posedge clk) disable iff (!arst_n)
		link_wr_en |-> (head_wr_en && !link_rd_en))
		else $error("list push without matching head update");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != STAT_OK) |->
		(rsp.result_address == '0 && rsp.block_bytes == '0))
		else $error("failed request reports an address or block size");
`endif

endmodule
